FILE: rtl/hkv_pkg.sv
// Package for the hashed key-value store: request and status codes, field widths,
// entry layout and the lookup result type. It has no dependencies.
package hkv_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = 1 + KEY_W + VAL_W;

    localparam int E_VAL_LSB = 0;
    localparam int E_KEY_LSB = VAL_W;
    localparam int E_VLD_BIT = VAL_W + KEY_W;

    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_PUT    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_STORED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic                    wr;
        logic [1:0]              status;
        logic signed [VAL_W-1:0] found;
    } t_row_res;

endpackage

FILE: rtl/hkv_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on hkv_pkg for the field widths.
interface hkv_req_if
    import hkv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output req_type, output key, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input key, input new_value,
                    output ready);
endinterface

interface hkv_rsp_if
    import hkv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

FILE: rtl/hashed_key_value_store.sv
// Hashed key-value store: BUCKETS buckets of WAYS entries of signed 32-bit keys and values,
// the bucket being the low bits of the key. After reset a clearing sweep writes one bucket
// row a cycle, over all BUCKETS rows, before the first request beat is accepted. Each request
// then has its bucket row read from the RAM, followed by the way compare and row write-back;
// a new request is accepted only once the last one has left the compare state. A response
// waiting in the output register holds the next request in its compare cycle. Depends on
// hkv_pkg, hkv_if, hkv_ram and hkv_row_upd.
module hashed_key_value_store
    import hkv_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkv_req_if.sink   i_req,
    hkv_rsp_if.source o_rsp
);
    localparam int IDX_W = $clog2(BUCKETS);
    localparam int ROW_W = WAYS * ENTRY_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_clr_idx, n_clr_idx;
    logic [1:0]              r_req_type, n_req_type;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [VAL_W-1:0]        r_new_value, n_new_value;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_status, n_status;
    logic signed [VAL_W-1:0] r_found, n_found;

    logic             accept;
    logic             load;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] upd_row;
    t_row_res         upd_res;

    assign i_req.ready       = (r_state == S_IDLE);
    assign accept            = i_req.valid && i_req.ready;
    assign load              = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found_value = r_found;

    assign ram_we    = (r_state == S_CLEAR) || (load && upd_res.wr);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_key[IDX_W-1:0];
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : upd_row;

    hkv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (i_req.key[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    hkv_row_upd #(
        .WAYS (WAYS)
    ) u_row_upd (
        .i_row       (ram_rdata),
        .i_req_type  (r_req_type),
        .i_key       (r_key),
        .i_new_value (r_new_value),
        .o_row       (upd_row),
        .o_res       (upd_res)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_req_type  = r_req_type;
        n_key       = r_key;
        n_new_value = r_new_value;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_found     = r_found;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req_type  = i_req.req_type;
                    n_key       = i_req.key;
                    n_new_value = i_req.new_value;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_status    = upd_res.status;
                    n_found     = upd_res.found;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
        r_req_type  <= n_req_type;
        r_key       <= n_key;
        r_new_value <= n_new_value;
        r_status    <= n_status;
        r_found     <= n_found;
    end

`ifndef ASSERT_OFF
    a_accept_then_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted request beat did not move to the compare cycle");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || o_rsp.ready))
        else $error("response loaded over a beat not yet taken");

    a_no_rw_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && accept && (ram_waddr == i_req.key[IDX_W-1:0])))
        else $error("row read and written in the same cycle");

    a_wr_only_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_LOOK)) |-> (r_req_type == REQ_PUT
                                             || r_req_type == REQ_DELETE))
        else $error("row written back for a request that changes nothing");
`endif
endmodule

FILE: rtl/hkv_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
module hkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/hkv_row_upd.sv
// Compares one bucket row against the request key and builds the updated row and result.
// Depends on hkv_pkg.
module hkv_row_upd
    import hkv_pkg::*;
#(
    parameter int WAYS = 4
) (
    input  logic [WAYS*ENTRY_W-1:0] i_row,
    input  logic [1:0]              i_req_type,
    input  logic [KEY_W-1:0]        i_key,
    input  logic [VAL_W-1:0]        i_new_value,
    output logic [WAYS*ENTRY_W-1:0] o_row,
    output t_row_res                o_res
);
    logic [WAYS-1:0]    hit_vec;
    logic [WAYS-1:0]    free_vec;
    logic [WAYS-1:0]    hit_1h;
    logic [WAYS-1:0]    free_1h;
    logic               any_hit;
    logic               any_free;
    logic [VAL_W-1:0]   hit_val;

    always_comb begin
        hit_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = i_row[w*ENTRY_W + E_VLD_BIT] &&
                          (i_row[w*ENTRY_W + E_KEY_LSB +: KEY_W] == i_key);
            free_vec[w] = !i_row[w*ENTRY_W + E_VLD_BIT];
        end
        hit_1h   = hit_vec & (~hit_vec + WAYS'(1));
        free_1h  = free_vec & (~free_vec + WAYS'(1));
        any_hit  = |hit_vec;
        any_free = |free_vec;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_1h[w]) begin
                hit_val = hit_val | i_row[w*ENTRY_W + E_VAL_LSB +: VAL_W];
            end
        end
    end

    always_comb begin
        o_row        = i_row;
        o_res.wr     = 1'b0;
        o_res.status = ST_MISS;
        o_res.found  = '0;
        case (i_req_type)
            REQ_GET: begin
                if (any_hit) begin
                    o_res.status = ST_HIT;
                    o_res.found  = hit_val;
                end
            end
            REQ_PUT: begin
                if (any_hit || any_free) begin
                    o_res.status = ST_STORED;
                    o_res.wr     = 1'b1;
                end else begin
                    o_res.status = ST_FULL;
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (any_hit) begin
                        if (hit_1h[w]) begin
                            o_row[w*ENTRY_W + E_VAL_LSB +: VAL_W] = i_new_value;
                        end
                    end else if (free_1h[w]) begin
                        o_row[w*ENTRY_W +: ENTRY_W] = {1'b1, i_key, i_new_value};
                    end
                end
            end
            REQ_DELETE: begin
                if (any_hit) begin
                    o_res.status = ST_HIT;
                    o_res.found  = hit_val;
                    o_res.wr     = 1'b1;
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_1h[w]) begin
                        o_row[w*ENTRY_W + E_VLD_BIT] = 1'b0;
                    end
                end
            end
            default: begin
                o_res.status = ST_MISS;
            end
        endcase
    end
endmodule
